@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is applied
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

@@ hdl/ttb_pkg.sv @@
// ----------------------------------------------------------------------------
// ttb_pkg
// widths and shared types of the triangle tangent basis block
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int IDX_W  = 16;
  localparam int POS_W  = 32;
  localparam int TEX_W  = 24;
  localparam int EDGE_W = POS_W + 1;
  localparam int DUV_W  = TEX_W + 1;
  localparam int NUM_W  = DUV_W + EDGE_W + 1;
  localparam int FRAC_W = 16;
  localparam int QUO_W  = POS_W + 1;

  typedef struct packed {
    logic              [IDX_W-1:0] idx;
    logic signed       [POS_W-1:0] px;
    logic signed       [POS_W-1:0] py;
    logic signed       [POS_W-1:0] pz;
    logic signed       [TEX_W-1:0] tu;
    logic signed       [TEX_W-1:0] tv;
  } corner_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_load;
  } mac_ctl_t;

endpackage

@@ hdl/ttb_mac.sv @@
// ----------------------------------------------------------------------------
// ttb_mac
// shared multiplier with registered product and a difference accumulator
// ----------------------------------------------------------------------------
module ttb_mac (
  input  logic                               clk,
  input  ttb_pkg::mac_ctl_t                  ctl,
  input  logic signed [ttb_pkg::DUV_W-1:0]   op_a,
  input  logic signed [ttb_pkg::EDGE_W-1:0]  op_b,
  output logic signed [ttb_pkg::NUM_W-1:0]   acc
);
  import ttb_pkg::*;

  logic signed [DUV_W+EDGE_W-1:0] prod_r;
  logic signed [NUM_W-1:0]        acc_r;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (ctl.acc_en) begin
      acc_r <= ctl.acc_load ? NUM_W'(prod_r) : acc_r - NUM_W'(prod_r);
    end
  end

  assign acc = acc_r;

endmodule

@@ hdl/ttb_div.sv @@
// ----------------------------------------------------------------------------
// ttb_div
// restoring divider, one quotient bit a cycle, q16.16 result with clamping
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttb_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [ttb_pkg::NUM_W-1:0]  num,
  input  logic signed [ttb_pkg::NUM_W-1:0]  den,
  output logic                              done,
  output logic        [ttb_pkg::POS_W-1:0]  quo,
  output logic                              sat
);
  import ttb_pkg::*;

  localparam int SH = QUO_W - FRAC_W;
  localparam logic [QUO_W-1:0] POS_LIM = QUO_W'(33'h0_7FFF_FFFF);
  localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(33'h0_8000_0000);
  localparam logic [5:0]       LAST_STEP = 6'(QUO_W - 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  dstate_t          state_r;
  logic             neg_r;
  logic             ovf_r;
  logic [NUM_W-1:0] d_r;
  logic [NUM_W-1:0] r_r;
  logic [QUO_W-1:0] s_r;
  logic [QUO_W-1:0] q_r;
  logic [5:0]       cnt_r;
  logic             done_r;
  logic [POS_W-1:0] quo_r;
  logic             sat_r;

  logic [NUM_W-1:0]    a_mag;
  logic [NUM_W-1:0]    d_mag;
  logic                big;
  logic [NUM_W:0]      trial;
  logic                ge;
  logic [NUM_W-1:0]    r_nxt;
  logic [QUO_W-1:0]    limit;
  logic                over;
  logic [QUO_W-1:0]    mag;

  always_comb begin
    a_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    d_mag = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
    big   = {SH'(0), a_mag} >= {d_mag, SH'(0)};
    trial = {r_r, s_r[QUO_W-1]};
    ge    = trial >= {1'b0, d_r};
    r_nxt = ge ? NUM_W'(trial - {1'b0, d_r}) : trial[NUM_W-1:0];
    limit = neg_r ? NEG_LIM : POS_LIM;
    over  = ovf_r || (q_r > limit);
    mag   = over ? limit : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            neg_r <= num[NUM_W-1] ^ den[NUM_W-1];
            d_r   <= d_mag;
            r_r   <= a_mag >> SH;
            s_r   <= {a_mag[SH-1:0], FRAC_W'(0)};
            q_r   <= '0;
            cnt_r <= '0;
            ovf_r <= big;
            state_r <= big ? D_FIN : D_RUN;
          end
        end
        D_RUN: begin
          r_r   <= r_nxt;
          s_r   <= {s_r[QUO_W-2:0], 1'b0};
          q_r   <= {q_r[QUO_W-2:0], ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == LAST_STEP) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          quo_r   <= neg_r ? POS_W'(0) - mag[POS_W-1:0] : mag[POS_W-1:0];
          sat_r   <= over;
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign sat  = sat_r;

  `ASSERT_NEXT(a_done_pulse, done_r, !done_r)
  `ASSERT_SAME(a_start_idle, start, state_r == D_IDLE)

endmodule

@@ hdl/triangle_tangent_basis.sv @@
// ----------------------------------------------------------------------------
// triangle_tangent_basis
// per-triangle tangent and binormal from corner positions and uvs
// ----------------------------------------------------------------------------
// corners arrive one transfer at a time; the first two of each triangle are
// held. on the third corner one shared multiplier forms the uv determinant
// and six numerators (seven products-of-differences), then one restoring
// divider turns each numerator into a q16.16 component at one quotient bit
// a cycle. a zero determinant ends the work after the first product pair
// with zero vectors and the degenerate flag. the input stalls while a
// triangle is computed and until its result transfer completes. with the
// enable bit (cfg_wr_data, written under cfg_wr_en) clear, corners are
// still held and counted but no result is produced.
`include "assert_macros.svh"

module triangle_tangent_basis (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic        [ttb_pkg::IDX_W-1:0]   in_vertex_index,
  input  logic signed [ttb_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [ttb_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [ttb_pkg::POS_W-1:0]   in_pos_z,
  input  logic signed [ttb_pkg::TEX_W-1:0]   in_tex_u,
  input  logic signed [ttb_pkg::TEX_W-1:0]   in_tex_v,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic        [ttb_pkg::IDX_W-1:0]   out_index_a,
  output logic        [ttb_pkg::IDX_W-1:0]   out_index_b,
  output logic        [ttb_pkg::IDX_W-1:0]   out_index_c,
  output logic signed [ttb_pkg::POS_W-1:0]   out_tangent_x,
  output logic signed [ttb_pkg::POS_W-1:0]   out_tangent_y,
  output logic signed [ttb_pkg::POS_W-1:0]   out_tangent_z,
  output logic signed [ttb_pkg::POS_W-1:0]   out_binormal_x,
  output logic signed [ttb_pkg::POS_W-1:0]   out_binormal_y,
  output logic signed [ttb_pkg::POS_W-1:0]   out_binormal_z,
  output logic                               out_degenerate,
  output logic                               out_saturated
);
  import ttb_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_DSTART, S_DWAIT, S_OUT} state_t;

  localparam logic [2:0] LAST_PAIR = 3'd6;
  localparam logic [2:0] LAST_DIV  = 3'd5;
  localparam logic [1:0] CORNER_C  = 2'd2;

  function automatic logic signed [EDGE_W-1:0] pos_diff(
    input logic signed [POS_W-1:0] a,
    input logic signed [POS_W-1:0] b
  );
    return EDGE_W'(a) - EDGE_W'(b);
  endfunction

  function automatic logic signed [DUV_W-1:0] tex_diff(
    input logic signed [TEX_W-1:0] a,
    input logic signed [TEX_W-1:0] b
  );
    return DUV_W'(a) - DUV_W'(b);
  endfunction

  state_t                  state_r;
  logic [1:0]              cnt_r;
  logic                    en_r;
  logic                    out_valid_r;
  corner_t                 held_r [2];
  logic [IDX_W-1:0]        idx_c_r;
  logic signed [EDGE_W-1:0] e0_r [3];
  logic signed [EDGE_W-1:0] e1_r [3];
  logic signed [DUV_W-1:0] du0_r, dv0_r, du1_r, dv1_r;
  logic [2:0]              pair_r;
  logic [1:0]              ph_r;
  logic [2:0]              div_k_r;
  logic signed [NUM_W-1:0] det_r;
  logic signed [NUM_W-1:0] num_r [6];
  logic [POS_W-1:0]        res_r [6];
  logic                    degen_r;
  logic                    sat_r;

  mac_ctl_t                mac_ctl;
  logic signed [DUV_W-1:0] op_a;
  logic signed [EDGE_W-1:0] op_b;
  logic signed [NUM_W-1:0] acc;
  logic                    second;
  logic [2:0]              k_wide;
  logic [1:0]              sel_k;
  logic                    div_done;
  logic [POS_W-1:0]        div_quo;
  logic                    div_sat;
  corner_t                 in_corner;

  assign in_corner = '{idx: in_vertex_index, px: in_pos_x, py: in_pos_y, pz: in_pos_z,
                       tu: in_tex_u, tv: in_tex_v};

  // operand selection: pair 0 is the determinant, 1..3 tangent, 4..6 binormal
  always_comb begin
    second  = (ph_r == 2'd1);
    k_wide  = (pair_r <= 3'd3) ? pair_r - 3'd1 : pair_r - 3'd4;
    sel_k   = k_wide[1:0];
    if (pair_r == 3'd0) begin
      op_a = second ? du1_r : du0_r;
      op_b = second ? EDGE_W'(dv0_r) : EDGE_W'(dv1_r);
    end else if (pair_r <= 3'd3) begin
      op_a = second ? dv0_r : dv1_r;
      op_b = second ? e1_r[sel_k] : e0_r[sel_k];
    end else begin
      op_a = second ? du0_r : du1_r;
      op_b = second ? e1_r[sel_k] : e0_r[sel_k];
    end
    mac_ctl.mul_en   = (state_r == S_MAC) && (ph_r == 2'd0 || ph_r == 2'd1);
    mac_ctl.acc_en   = (state_r == S_MAC) && (ph_r == 2'd1 || ph_r == 2'd2);
    mac_ctl.acc_load = (ph_r == 2'd1);
  end

  ttb_mac u_mac (
    .clk  (clk),
    .ctl  (mac_ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  ttb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DSTART),
    .num   (num_r[div_k_r]),
    .den   (det_r),
    .done  (div_done),
    .quo   (div_quo),
    .sat   (div_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      en_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        en_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (cnt_r != CORNER_C) begin
              held_r[cnt_r[0]] <= in_corner;
              cnt_r <= cnt_r + 2'd1;
            end else begin
              cnt_r <= '0;
              if (en_r) begin
                // edges and uv deltas relative to the first corner
                idx_c_r <= in_vertex_index;
                e0_r[0] <= pos_diff(held_r[1].px, held_r[0].px);
                e0_r[1] <= pos_diff(held_r[1].py, held_r[0].py);
                e0_r[2] <= pos_diff(held_r[1].pz, held_r[0].pz);
                e1_r[0] <= pos_diff(in_pos_x, held_r[0].px);
                e1_r[1] <= pos_diff(in_pos_y, held_r[0].py);
                e1_r[2] <= pos_diff(in_pos_z, held_r[0].pz);
                du0_r   <= tex_diff(held_r[1].tu, held_r[0].tu);
                dv0_r   <= tex_diff(held_r[1].tv, held_r[0].tv);
                du1_r   <= tex_diff(in_tex_u, held_r[0].tu);
                dv1_r   <= tex_diff(in_tex_v, held_r[0].tv);
                pair_r  <= '0;
                ph_r    <= '0;
                sat_r   <= 1'b0;
                degen_r <= 1'b0;
                state_r <= S_MAC;
              end
            end
          end
        end
        S_MAC: begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd3) begin
            if (pair_r == 3'd0) begin
              det_r <= acc;
              if (acc == '0) begin
                // degenerate uv mapping: zero vectors, no division
                for (int i = 0; i < 6; i++) res_r[i] <= '0;
                degen_r     <= 1'b1;
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end else begin
                pair_r <= pair_r + 3'd1;
              end
            end else begin
              num_r[pair_r - 3'd1] <= acc;
              if (pair_r == LAST_PAIR) begin
                div_k_r <= '0;
                state_r <= S_DSTART;
              end else begin
                pair_r <= pair_r + 3'd1;
              end
            end
          end
        end
        S_DSTART: begin
          state_r <= S_DWAIT;
        end
        S_DWAIT: begin
          if (div_done) begin
            res_r[div_k_r] <= div_quo;
            sat_r <= sat_r | div_sat;
            if (div_k_r == LAST_DIV) begin
              out_valid_r <= 1'b1;
              state_r     <= S_OUT;
            end else begin
              div_k_r <= div_k_r + 3'd1;
              state_r <= S_DSTART;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_index_a    = held_r[0].idx;
  assign out_index_b    = held_r[1].idx;
  assign out_index_c    = idx_c_r;
  assign out_tangent_x  = res_r[0];
  assign out_tangent_y  = res_r[1];
  assign out_tangent_z  = res_r[2];
  assign out_binormal_x = res_r[3];
  assign out_binormal_y = res_r[4];
  assign out_binormal_z = res_r[5];
  assign out_degenerate = degen_r;
  assign out_saturated  = sat_r;

  `ASSERT_SAME(a_stall_while_out, out_valid_r, in_stall)
  `ASSERT_SAME(a_degen_zero, out_valid_r && degen_r, !sat_r && res_r[0] == '0 && res_r[5] == '0)
  `ASSERT_NEXT(a_out_retire, out_valid_r && !out_stall, !out_valid_r)
  `ASSERT_SAME(a_out_state, out_valid_r, state_r == S_OUT)

endmodule
